/* design/integer_partition_count_defines.svh */
// ----------------------------------------------------------------------------
// integer_partition_count_defines.svh
// Assertion macros shared by the partition counter RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PARTITION_COUNT_DEFINES_SVH
`define INTEGER_PARTITION_COUNT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ipc_pkg.sv */
// ----------------------------------------------------------------------------
// ipc_pkg
// Constants and types for the restricted integer partition counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

    localparam int MAX_TOTAL = 64;
    localparam int ROW_DEPTH = MAX_TOTAL + 1;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);

    localparam int FIELD_W   = 7;
    localparam int COUNT_W   = 21;

    localparam int S_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COUNT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_ADD,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

/* design/integer_partition_count.sv */
// ----------------------------------------------------------------------------
// integer_partition_count
// Counts partitions of a total into parts no larger than a given limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata: total in the low 7 bits,
//   largest_part in the next 7. Each word gives exactly one result word on
//   m_tvalid/m_tready/m_tdata (count) with m_tuser set for an invalid item
//   (zero total, zero limit or total above MAX_TOTAL, count then 0).
//   A limit above the total is clamped to the total.
//   The count is built in a row memory of MAX_TOTAL+1 entries by one shared
//   21-bit adder. Each row update is a registered read of two entries, then
//   an add and write back. A valid item with total T and clamped limit L
//   first clears entries 0..T, then for each part p = 1..L updates the
//   entries p..T in turn before its result is loaded; an invalid item goes
//   straight to the result step.
//   s_tready is high only while the sequencer is idle; one item at a time.
//   A finished result sits in the output register, so the next item can be
//   accepted while the receiver stalls; a further result then waits.
//   Reset (aresetn low, synchronous) empties the output and idles the
//   sequencer; the row memory needs no clearing, each item rewrites it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_partition_count_defines.svh"

module integer_partition_count (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: total [6:0], largest_part [13:7], zero pad [15:14]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ipc_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: count [20:0], zero pad [23:21]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ipc_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: invalid [0]
    output logic                                m_tuser
);

    localparam int AW = ipc_pkg::ADDR_W;
    localparam int CW = ipc_pkg::COUNT_W;
    localparam int FW = ipc_pkg::FIELD_W;

    logic [FW-1:0] s_total;
    logic [FW-1:0] s_largest_part;
    logic          item_bad;

    ipc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   tot_reg, tot_next;
    logic [AW-1:0]   lim_reg, lim_next;
    logic [AW-1:0]   part_reg, part_next;
    logic [AW-1:0]   amt_reg, amt_next;
    logic [CW-1:0]   res_count_reg, res_count_next;
    logic            res_invalid_reg, res_invalid_next;

    logic            m_tvalid_reg;
    logic [CW-1:0]   m_count_reg;
    logic            m_invalid_reg;
    logic            out_load;

    // row memory and its shared adder
    logic [CW-1:0]   partial_counts_mem [0:ipc_pkg::MAX_TOTAL];
    logic            mem_we;
    logic            mem_re;
    logic [CW-1:0]   mem_wdata;
    logic [AW-1:0]   rd_b_addr;
    logic [CW-1:0]   rd_a_reg;
    logic [CW-1:0]   rd_b_reg;
    logic [CW-1:0]   sum;

    assign s_total        = s_tdata[FW-1:0];
    assign s_largest_part = s_tdata[2*FW-1:FW];
    assign item_bad       = (s_total == '0) || (s_largest_part == '0) ||
                            (int'(s_total) > ipc_pkg::MAX_TOTAL);

    assign s_tready  = (state_reg == ipc_pkg::ST_IDLE);
    assign rd_b_addr = amt_reg - part_reg;
    assign sum       = rd_a_reg + rd_b_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            partial_counts_mem[amt_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rd_a_reg <= partial_counts_mem[amt_reg];
            rd_b_reg <= partial_counts_mem[rd_b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        tot_reg         <= tot_next;
        lim_reg         <= lim_next;
        part_reg        <= part_next;
        amt_reg         <= amt_next;
        res_count_reg   <= res_count_next;
        res_invalid_reg <= res_invalid_next;
    end

    always_comb begin
        state_next       = state_reg;
        tot_next         = tot_reg;
        lim_next         = lim_reg;
        part_next        = part_reg;
        amt_next         = amt_reg;
        res_count_next   = res_count_reg;
        res_invalid_next = res_invalid_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_wdata        = '0;
        out_load         = 1'b0;

        case (state_reg)
            ipc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (item_bad) begin
                        res_count_next   = '0;
                        res_invalid_next = 1'b1;
                        state_next       = ipc_pkg::ST_RESULT;
                    end else begin
                        tot_next         = AW'(s_total);
                        lim_next         = (s_largest_part > s_total) ?
                                           AW'(s_total) : AW'(s_largest_part);
                        amt_next         = '0;
                        res_invalid_next = 1'b0;
                        state_next       = ipc_pkg::ST_CLEAR;
                    end
                end
            end
            ipc_pkg::ST_CLEAR: begin
                // one way to make zero, none for anything else
                mem_we    = 1'b1;
                mem_wdata = (amt_reg == '0) ? CW'(1) : '0;
                if (amt_reg == tot_reg) begin
                    part_next  = AW'(1);
                    amt_next   = AW'(1);
                    state_next = ipc_pkg::ST_READ;
                end else begin
                    amt_next = amt_reg + AW'(1);
                end
            end
            ipc_pkg::ST_READ: begin
                mem_re     = 1'b1;
                state_next = ipc_pkg::ST_ADD;
            end
            ipc_pkg::ST_ADD: begin
                mem_we     = 1'b1;
                mem_wdata  = sum;
                state_next = ipc_pkg::ST_READ;
                if (amt_reg == tot_reg) begin
                    if (part_reg == lim_reg) begin
                        // last update lands on the total itself
                        res_count_next = sum;
                        state_next     = ipc_pkg::ST_RESULT;
                    end else begin
                        part_next = part_reg + AW'(1);
                        amt_next  = part_reg + AW'(1);
                    end
                end else begin
                    amt_next = amt_reg + AW'(1);
                end
            end
            ipc_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ipc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ipc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_count_reg   <= res_count_reg;
            m_invalid_reg <= res_invalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ipc_pkg::M_TDATA_W'(m_count_reg);
    assign m_tuser  = m_invalid_reg;

    `IPC_ASSERT_SAME(a_invalid_zero, m_tvalid && m_tuser, m_tdata == '0, "invalid word with nonzero count")
    `IPC_ASSERT_SAME(a_mem_one_op, 1'b1, !(mem_we && mem_re), "row memory read and written together")
    `IPC_ASSERT_SAME(a_step_range, (state_reg == ipc_pkg::ST_READ) || (state_reg == ipc_pkg::ST_ADD), (amt_reg >= part_reg) && (amt_reg <= tot_reg) && (part_reg <= lim_reg), "row update index out of range")
    `IPC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted a second word while busy")

endmodule

`default_nettype wire
